FILE: hdl/cle_pkg.sv
// Shared types and constants of the console line editor.
`timescale 1ns / 1ps

package cle_pkg;

    localparam int LINE_MAX  = 32;
    localparam int ADDR_W    = $clog2(LINE_MAX);
    localparam int FILL_W    = 6;
    localparam int BYTE_W    = 8;
    localparam int ECHO_MAX  = 3;
    localparam int ECHO_CW   = $clog2(ECHO_MAX + 1);

    localparam logic [BYTE_W-1:0] CH_BS       = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF       = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_SP       = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TILDE    = 8'h7e;
    localparam logic [BYTE_W-1:0] CH_DEL      = 8'h7f;
    localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;

    localparam logic [FILL_W-1:0] MAX_CHARS_RESET = FILL_W'(LINE_MAX);
    localparam logic [FILL_W-1:0] LINE_MAX_FILL   = FILL_W'(LINE_MAX);

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_LINE = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              end_of_input;
    } in_item_t;

    typedef struct packed {
        kind_t             out_kind;
        logic [BYTE_W-1:0] out_byte;
        logic              closed_by_eof;
        logic              last_flag;
    } out_item_t;

endpackage

FILE: hdl/console_line_editor_top.sv
// Console line editor: line store, echo and line-close sequencer.
//
// Each request is taken only while the sequencer is idle; the results it causes
// leave one per cycle through an output register unless the result channel
// stalls. A printable byte or an erase is accepted and echoed; a line close by
// CR or LF is accepted, then sends two echo bytes, each stored character and
// the line-end record; an end of input skips the echo. The line store is a
// 32 x 8 synchronous memory read one address per cycle, and the line bytes
// stream from it one per cycle unless stalled. No clearing pass follows reset.
`timescale 1ns / 1ps

module console_line_editor_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cle_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output cle_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [5:0]         cfg_data
);
    import cle_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ECHO = 4'b0010,
        S_LINE = 4'b0100,
        S_END  = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [FILL_W-1:0]            fill_count_reg, fill_count_next;
    logic [FILL_W-1:0]            max_chars_reg;
    logic [FILL_W-1:0]            idx_reg, idx_next;
    logic [ECHO_MAX-1:0][BYTE_W-1:0] echo_buf_reg, echo_buf_next;
    logic [ECHO_CW-1:0]           echo_left_reg, echo_left_next;
    logic                         close_pending_reg, close_pending_next;
    logic                         eof_flag_reg, eof_flag_next;
    logic                         out_valid_reg, out_valid_next;
    out_item_t                    out_item_reg, out_item_next;

    logic [BYTE_W-1:0]            line_store [LINE_MAX];
    logic [BYTE_W-1:0]            rd_data_reg;
    logic [ADDR_W-1:0]            rd_addr;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [BYTE_W-1:0]            wr_data;

    logic                         accept;
    logic                         slot_free;
    logic [FILL_W-1:0]            limit;
    logic [BYTE_W-1:0]            c;
    logic [FILL_W-1:0]            idx_inc;
    state_t                       close_state;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    assign limit       = (max_chars_reg < LINE_MAX_FILL) ? max_chars_reg : LINE_MAX_FILL;
    assign c           = in_data.rx_byte;
    assign idx_inc     = idx_reg + FILL_W'(1);
    assign close_state = (fill_count_reg == '0) ? S_END : S_LINE;

    always_comb
    begin
        state_next         = state_reg;
        fill_count_next    = fill_count_reg;
        idx_next           = idx_reg;
        echo_buf_next      = echo_buf_reg;
        echo_left_next     = echo_left_reg;
        close_pending_next = close_pending_reg;
        eof_flag_next      = eof_flag_reg;
        out_valid_next     = out_valid_reg && out_stall;
        out_item_next      = out_item_reg;
        wr_en              = 1'b0;
        wr_addr            = fill_count_reg[ADDR_W-1:0];
        wr_data            = c;
        rd_addr            = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_data.end_of_input)
                    begin
                        eof_flag_next = 1'b1;
                        idx_next      = '0;
                        state_next    = close_state;
                    end
                    else if (c == CH_CR || c == CH_LF)
                    begin
                        echo_buf_next      = {CH_NUL, CH_LF, CH_CR};
                        echo_left_next     = ECHO_CW'(2);
                        close_pending_next = 1'b1;
                        eof_flag_next      = 1'b0;
                        state_next         = S_ECHO;
                    end
                    else if (c == CH_BS || c == CH_DEL)
                    begin
                        if (fill_count_reg != '0)
                        begin
                            fill_count_next    = fill_count_reg - FILL_W'(1);
                            echo_buf_next      = {CH_BS, CH_SP, CH_BS};
                            echo_left_next     = ECHO_CW'(3);
                            close_pending_next = 1'b0;
                            state_next         = S_ECHO;
                        end
                    end
                    else if (c >= CH_SP && c < CH_TILDE)
                    begin
                        if (fill_count_reg < limit)
                        begin
                            wr_en              = 1'b1;
                            fill_count_next    = fill_count_reg + FILL_W'(1);
                            echo_buf_next      = {CH_NUL, CH_NUL, c};
                            echo_left_next     = ECHO_CW'(1);
                            close_pending_next = 1'b0;
                            state_next         = S_ECHO;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ECHO:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.out_kind      = KIND_ECHO;
                    out_item_next.out_byte      = echo_buf_reg[0];
                    out_item_next.closed_by_eof = 1'b0;
                    out_item_next.last_flag     = (echo_left_reg == ECHO_CW'(1))
                                                  && !close_pending_reg;
                    echo_buf_next  = {CH_NUL, echo_buf_reg[2], echo_buf_reg[1]};
                    echo_left_next = echo_left_reg - ECHO_CW'(1);
                    if (echo_left_reg == ECHO_CW'(1))
                    begin
                        idx_next   = '0;
                        state_next = close_pending_reg ? close_state : S_IDLE;
                    end
                end
            end
            S_LINE:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.out_kind      = KIND_LINE;
                    out_item_next.out_byte      = rd_data_reg;
                    out_item_next.closed_by_eof = 1'b0;
                    out_item_next.last_flag     = 1'b0;
                    idx_next = idx_inc;
                    rd_addr  = idx_inc[ADDR_W-1:0];
                    if (idx_inc == fill_count_reg)
                    begin
                        state_next = S_END;
                    end
                end
            end
            S_END:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_item_next.out_kind      = KIND_END;
                    out_item_next.out_byte      = BYTE_W'(fill_count_reg);
                    out_item_next.closed_by_eof = eof_flag_reg;
                    out_item_next.last_flag     = 1'b1;
                    fill_count_next = '0;
                    idx_next        = '0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_store[wr_addr] <= wr_data;
        end
        rd_data_reg <= line_store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            fill_count_reg    <= '0;
            max_chars_reg     <= MAX_CHARS_RESET;
            idx_reg           <= '0;
            echo_left_reg     <= '0;
            close_pending_reg <= 1'b0;
            eof_flag_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            fill_count_reg    <= fill_count_next;
            idx_reg           <= idx_next;
            echo_left_reg     <= echo_left_next;
            close_pending_reg <= close_pending_next;
            eof_flag_reg      <= eof_flag_next;
            out_valid_reg     <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_chars_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        echo_buf_reg <= echo_buf_next;
        out_item_reg <= out_item_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= LINE_MAX_FILL)
        else $error("line fill count beyond store depth");

    a_line_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINE) |-> (idx_reg < fill_count_reg))
        else $error("line read index past fill count");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_END) && slot_free |=> (fill_count_reg == '0) && out_valid_reg
                                              && out_item_reg.last_flag)
        else $error("line end did not clear the line");

endmodule

FILE: sim/tb_console_line_editor_top.sv
// Self-checking testbench for the console line editor: echo, erase, line close and limit.
`timescale 1ns / 1ps

module tb_console_line_editor_top;

    import cle_pkg::*;

    localparam int SETTLE_CYCLES = 40;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    in_item_t   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data = '0;

    in_item_t   rx_backlog[$];
    out_item_t  tx_expected[$];

    logic [7:0] line_chars[LINE_MAX];
    int         line_len = 0;
    logic [5:0] max_chars_q = MAX_CHARS_RESET;

    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         mismatch_count = 0;

    console_line_editor_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch %s: got %0d, wanted %0d at %0t", field, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic push_result(input kind_t kind, input logic [7:0] value, input logic eof);
        out_item_t r;
        r.out_kind      = kind;
        r.out_byte      = value;
        r.closed_by_eof = eof;
        r.last_flag     = 1'b0;
        tx_expected.push_back(r);
    endtask

    task automatic close_line(input logic eof);
        for (int i = 0; i < line_len; i++)
        begin
            push_result(KIND_LINE, line_chars[i], 1'b0);
        end
        push_result(KIND_END, 8'(line_len), eof);
        line_len = 0;
    endtask

    task automatic edit_line(input in_item_t req);
        int first;
        int lim;
        first = tx_expected.size();
        lim   = (max_chars_q < LINE_MAX) ? int'(max_chars_q) : LINE_MAX;
        if (req.end_of_input)
        begin
            close_line(1'b1);
        end
        else if (req.rx_byte == CH_CR || req.rx_byte == CH_LF)
        begin
            push_result(KIND_ECHO, CH_CR, 1'b0);
            push_result(KIND_ECHO, CH_LF, 1'b0);
            close_line(1'b0);
        end
        else if (req.rx_byte == CH_BS || req.rx_byte == CH_DEL)
        begin
            if (line_len > 0)
            begin
                line_len--;
                push_result(KIND_ECHO, CH_BS, 1'b0);
                push_result(KIND_ECHO, CH_SP, 1'b0);
                push_result(KIND_ECHO, CH_BS, 1'b0);
            end
        end
        else if (req.rx_byte >= CH_SP && req.rx_byte < CH_TILDE)
        begin
            if (line_len < lim)
            begin
                line_chars[line_len] = req.rx_byte;
                line_len++;
                push_result(KIND_ECHO, req.rx_byte, 1'b0);
            end
        end
        if (tx_expected.size() > first)
        begin
            tx_expected[tx_expected.size() - 1].last_flag = 1'b1;
        end
    endtask

    // Hold a stalled request; otherwise offer the next one or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (rx_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= rx_backlog.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (out_valid && !out_stall)
            begin
                if (tx_expected.size() == 0)
                begin
                    report_mismatch("result with nothing pending", int'(out_data), 0);
                end
                else
                begin
                    want = tx_expected.pop_front();
                    if (out_data.out_kind !== want.out_kind)
                        report_mismatch("out_kind", int'(out_data.out_kind),
                                        int'(want.out_kind));
                    if (out_data.out_byte !== want.out_byte)
                        report_mismatch("out_byte", int'(out_data.out_byte),
                                        int'(want.out_byte));
                    if (out_data.closed_by_eof !== want.closed_by_eof)
                        report_mismatch("closed_by_eof", int'(out_data.closed_by_eof),
                                        int'(want.closed_by_eof));
                    if (out_data.last_flag !== want.last_flag)
                        report_mismatch("last_flag", int'(out_data.last_flag),
                                        int'(want.last_flag));
                end
            end
            if (in_valid && !in_stall)
            begin
                edit_line(in_data);
            end
        end
    end

    task automatic queue_rx(input logic [7:0] value, input logic eoi);
        in_item_t it;
        it.rx_byte      = value;
        it.end_of_input = eoi;
        rx_backlog.push_back(it);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (rx_backlog.size() != 0 || in_valid || tx_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_chars(input logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        max_chars_q = value;
    endtask

    task automatic queue_random_lines(input int budget);
        int         sent;
        int         len;
        int         lim;
        logic [7:0] value;
        logic       eoi;
        sent = 0;
        lim  = (max_chars_q < LINE_MAX) ? int'(max_chars_q) : LINE_MAX;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                len = ($urandom_range(0, 3) == 0) ? lim + 2
                                                  : $urandom_range(0, (lim < 6) ? lim + 1 : 6);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 99) < 12)
                        queue_rx($urandom_range(0, 1) ? CH_BS : CH_DEL, 1'b0);
                    else
                        queue_rx(8'($urandom_range(32'h20, 32'h7d)), 1'b0);
                    sent++;
                end
                case ($urandom_range(0, 9))
                    0: ;
                    1, 2:
                    begin
                        queue_rx(8'($urandom), 1'b1);
                        sent++;
                    end
                    default:
                    begin
                        queue_rx($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
                        sent++;
                    end
                endcase
            end
            else
            begin
                value = 8'($urandom);
                eoi   = ($urandom_range(0, 15) == 0);
                queue_rx(value, eoi);
                if (eoi || value == CH_CR || value == CH_LF || value == CH_BS
                        || value == CH_DEL || (value >= CH_SP && value < CH_TILDE))
                    sent++;
            end
        end
    endtask

    initial
    begin
        logic [5:0] cfg_plan[7];
        int         send_mode[4];
        int         recv_mode[4];
        cfg_plan  = '{6'd2, 6'd0, 6'd1, 6'd63, 6'd33, 6'd32, 6'd0};
        send_mode = '{0, 84, 0, 25};
        recv_mode = '{0, 0, 84, 25};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_rx(CH_SP, 1'b0);
        queue_rx(8'h7d, 1'b0);
        queue_rx(CH_TILDE, 1'b0);
        queue_rx(CH_NUL, 1'b0);
        queue_rx(8'hff, 1'b0);
        queue_rx(8'h1f, 1'b0);
        queue_rx(CH_BS, 1'b0);
        queue_rx(CH_DEL, 1'b0);
        queue_rx(CH_BS, 1'b0);
        queue_rx(CH_DEL, 1'b0);
        queue_rx("H", 1'b0);
        queue_rx(CH_CR, 1'b0);
        queue_rx(CH_LF, 1'b0);
        queue_rx("Z", 1'b0);
        queue_rx(8'hff, 1'b1);
        queue_rx(CH_NUL, 1'b1);
        queue_rx(8'h80, 1'b0);
        queue_rx("a", 1'b0);
        queue_rx("b", 1'b0);
        queue_rx("c", 1'b0);
        queue_rx("d", 1'b0);
        wait_idle();

        // Leave the directed line open so the first write lowers the limit mid-line.
        for (int p = 0; p < 7; p++)
        begin
            write_max_chars((p == 6) ? 6'($urandom_range(0, 63)) : cfg_plan[p]);
            send_idle_pct  = send_mode[p % 4];
            recv_stall_pct = recv_mode[p % 4];
            queue_random_lines(8);
            wait_idle();
        end

        if (mismatch_count == 0 && tx_expected.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
hdl/cle_pkg.sv
hdl/console_line_editor_top.sv
sim/tb_console_line_editor_top.sv
